// ===== rtl/hee_pkg.sv =====
`timescale 1ns / 1ps

package hee_pkg;

    localparam int CP_W       = 21;
    localparam int WIDE_W     = 24;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int IN_DATA_W  = 24;

    typedef logic [7:0]          t_byte;
    typedef logic [CP_W-1:0]     t_cp;
    typedef logic [WIDE_W-1:0]   t_wide;
    typedef logic [2:0]          t_pow;
    typedef logic [2:0]          t_idx;
    typedef logic [3:0]          t_digit;
    typedef logic [FIFO_AW-1:0]  t_fifo_ptr;
    typedef logic [FIFO_AW:0]    t_fifo_cnt;

    typedef enum logic [2:0] {
        K_PASS,
        K_AMP,
        K_QUOT,
        K_APOS,
        K_LT,
        K_GT,
        K_NUM
    } t_kind;

    typedef struct packed {
        t_kind kind;
        t_cp   cp;
        t_pow  pow;
    } t_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TEXT,
        ST_DIGIT,
        ST_SEMI
    } t_back_state;

    localparam t_byte CH_AMP   = 8'h26;
    localparam t_byte CH_HASH  = 8'h23;
    localparam t_byte CH_SEMI  = 8'h3b;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_THREE = 8'h33;
    localparam t_byte CH_NINE  = 8'h39;
    localparam t_byte CH_A     = 8'h61;
    localparam t_byte CH_M     = 8'h6d;
    localparam t_byte CH_P     = 8'h70;
    localparam t_byte CH_Q     = 8'h71;
    localparam t_byte CH_U     = 8'h75;
    localparam t_byte CH_O     = 8'h6f;
    localparam t_byte CH_T     = 8'h74;
    localparam t_byte CH_L     = 8'h6c;
    localparam t_byte CH_G     = 8'h67;

    localparam t_cp CP_AMP   = 21'h26;
    localparam t_cp CP_QUOT  = 21'h22;
    localparam t_cp CP_APOS  = 21'h27;
    localparam t_cp CP_LT    = 21'h3c;
    localparam t_cp CP_GT    = 21'h3e;
    localparam t_cp CP_ASCII_LIMIT = 21'd128;

    function automatic t_wide pow10(t_pow p);
        t_wide v;
        case (p)
            3'd0:    v = 24'd1;
            3'd1:    v = 24'd10;
            3'd2:    v = 24'd100;
            3'd3:    v = 24'd1000;
            3'd4:    v = 24'd10000;
            3'd5:    v = 24'd100000;
            3'd6:    v = 24'd1000000;
            default: v = 24'd10000000;
        endcase
        return v;
    endfunction

    function automatic t_wide dec_step(t_digit k, t_pow p);
        return t_wide'(k) * pow10(p);
    endfunction

    // Index of the final text byte for each kind; numeric runs continue with digits.
    function automatic t_idx text_last(t_kind k);
        t_idx v;
        unique case (k)
            K_AMP:   v = 3'd4;
            K_QUOT:  v = 3'd5;
            K_APOS:  v = 3'd5;
            K_LT:    v = 3'd3;
            K_GT:    v = 3'd3;
            K_NUM:   v = 3'd1;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    function automatic t_byte text_byte(t_kind k, t_idx idx);
        t_byte b;
        b = CH_AMP;
        case (k)
            K_AMP: begin
                case (idx)
                    3'd1:    b = CH_A;
                    3'd2:    b = CH_M;
                    3'd3:    b = CH_P;
                    3'd4:    b = CH_SEMI;
                    default: b = CH_AMP;
                endcase
            end
            K_QUOT: begin
                case (idx)
                    3'd1:    b = CH_Q;
                    3'd2:    b = CH_U;
                    3'd3:    b = CH_O;
                    3'd4:    b = CH_T;
                    3'd5:    b = CH_SEMI;
                    default: b = CH_AMP;
                endcase
            end
            K_APOS: begin
                case (idx)
                    3'd1:    b = CH_HASH;
                    3'd2:    b = CH_ZERO;
                    3'd3:    b = CH_THREE;
                    3'd4:    b = CH_NINE;
                    3'd5:    b = CH_SEMI;
                    default: b = CH_AMP;
                endcase
            end
            K_LT: begin
                case (idx)
                    3'd1:    b = CH_L;
                    3'd2:    b = CH_T;
                    3'd3:    b = CH_SEMI;
                    default: b = CH_AMP;
                endcase
            end
            K_GT: begin
                case (idx)
                    3'd1:    b = CH_G;
                    3'd2:    b = CH_T;
                    3'd3:    b = CH_SEMI;
                    default: b = CH_AMP;
                endcase
            end
            K_NUM: begin
                case (idx)
                    3'd1:    b = CH_HASH;
                    default: b = CH_AMP;
                endcase
            end
            default: b = CH_AMP;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/hee_front.sv =====
`timescale 1ns / 1ps

module hee_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hee_pkg::t_cp   i_cp,
    output logic           o_push,
    input  logic           i_push_ready,
    output hee_pkg::t_item o_item
);

    logic           r_valid;
    hee_pkg::t_item r_item;
    hee_pkg::t_item n_item;

    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.cp  = i_cp;
        n_item.pow = '0;
        unique case (i_cp)
            hee_pkg::CP_AMP:  n_item.kind = hee_pkg::K_AMP;
            hee_pkg::CP_QUOT: n_item.kind = hee_pkg::K_QUOT;
            hee_pkg::CP_APOS: n_item.kind = hee_pkg::K_APOS;
            hee_pkg::CP_LT:   n_item.kind = hee_pkg::K_LT;
            hee_pkg::CP_GT:   n_item.kind = hee_pkg::K_GT;
            default: begin
                if (i_cp < hee_pkg::CP_ASCII_LIMIT) begin
                    n_item.kind = hee_pkg::K_PASS;
                end else begin
                    n_item.kind = hee_pkg::K_NUM;
                end
            end
        endcase
        // leading power of ten = number of decimal thresholds reached
        for (int j = 1; j < 7; j++) begin
            if ({3'b000, i_cp} >= hee_pkg::pow10(3'(j))) begin
                n_item.pow = n_item.pow + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/hee_fifo.sv =====
`timescale 1ns / 1ps

module hee_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hee_pkg::t_item i_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output hee_pkg::t_item o_item,
    input  logic           i_pop
);

    hee_pkg::t_item       r_mem [hee_pkg::FIFO_DEPTH];
    hee_pkg::t_fifo_ptr   r_wr;
    hee_pkg::t_fifo_ptr   r_rd;
    hee_pkg::t_fifo_cnt   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_push_ready = r_count != hee_pkg::t_fifo_cnt'(hee_pkg::FIFO_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_item       = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== rtl/hee_back.sv =====
`timescale 1ns / 1ps

module hee_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  hee_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output hee_pkg::t_byte o_tdata,
    output logic           o_tlast
);

    hee_pkg::t_back_state r_state;
    hee_pkg::t_back_state n_state;
    hee_pkg::t_kind       r_kind;
    hee_pkg::t_cp         r_rem;
    hee_pkg::t_pow        r_pow;
    hee_pkg::t_idx        r_idx;
    logic                 r_tvalid;
    hee_pkg::t_byte       r_tdata;
    logic                 r_tlast;

    logic                 advance;
    hee_pkg::t_byte       cur_byte;
    logic                 cur_last;
    hee_pkg::t_digit      dig;
    hee_pkg::t_wide       sub;

    assign advance  = (r_state != hee_pkg::ST_IDLE) && (!r_tvalid || i_tready);
    assign o_pop    = i_pop_valid && ((r_state == hee_pkg::ST_IDLE) || (advance && cur_last));
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

    // one decimal digit per step: largest multiple of the current power that fits
    always_comb begin
        dig = '0;
        sub = '0;
        for (int k = 1; k < 10; k++) begin
            if ({3'b000, r_rem} >= hee_pkg::dec_step(4'(k), r_pow)) begin
                dig = 4'(k);
                sub = hee_pkg::dec_step(4'(k), r_pow);
            end
        end
    end

    always_comb begin
        cur_byte = '0;
        cur_last = 1'b0;
        unique case (r_state)
            hee_pkg::ST_TEXT: begin
                if (r_kind == hee_pkg::K_PASS) begin
                    cur_byte = r_rem[7:0];
                end else begin
                    cur_byte = hee_pkg::text_byte(r_kind, r_idx);
                end
                cur_last = (r_kind != hee_pkg::K_NUM) &&
                           (r_idx == hee_pkg::text_last(r_kind));
            end
            hee_pkg::ST_DIGIT: begin
                cur_byte = hee_pkg::CH_ZERO + {4'b0000, dig};
            end
            hee_pkg::ST_SEMI: begin
                cur_byte = hee_pkg::CH_SEMI;
                cur_last = 1'b1;
            end
            default: begin
                cur_byte = '0;
                cur_last = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hee_pkg::ST_IDLE: begin
                if (i_pop_valid) begin
                    n_state = hee_pkg::ST_TEXT;
                end
            end
            hee_pkg::ST_TEXT: begin
                if (advance) begin
                    if (r_kind == hee_pkg::K_NUM && r_idx == hee_pkg::text_last(r_kind)) begin
                        n_state = hee_pkg::ST_DIGIT;
                    end else if (cur_last) begin
                        n_state = i_pop_valid ? hee_pkg::ST_TEXT : hee_pkg::ST_IDLE;
                    end
                end
            end
            hee_pkg::ST_DIGIT: begin
                if (advance && r_pow == '0) begin
                    n_state = hee_pkg::ST_SEMI;
                end
            end
            hee_pkg::ST_SEMI: begin
                if (advance) begin
                    n_state = i_pop_valid ? hee_pkg::ST_TEXT : hee_pkg::ST_IDLE;
                end
            end
            default: n_state = hee_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hee_pkg::ST_IDLE;
            r_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (advance) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_tdata <= cur_byte;
            r_tlast <= cur_last;
        end
        if (o_pop) begin
            r_kind <= i_item.kind;
            r_rem  <= i_item.cp;
            r_pow  <= i_item.pow;
            r_idx  <= '0;
        end else if (advance) begin
            if (r_state == hee_pkg::ST_TEXT) begin
                r_idx <= r_idx + 3'd1;
            end
            if (r_state == hee_pkg::ST_DIGIT) begin
                r_rem <= r_rem - sub[hee_pkg::CP_W-1:0];
                r_pow <= r_pow - 3'd1;
            end
        end
    end

endmodule

// ===== rtl/html_entity_escaper_unit.sv =====
`timescale 1ns / 1ps

// HTML escaper: each input beat carries one code point; the output gives its
// escaped text one byte per beat with tlast on the final byte. Code points
// below 128 pass through as one byte, the five markup characters become
// &amp; &quot; &#039; &lt; &gt;, and code points of 128 and above become
// "&#" plus decimal digits plus ";". The output sequencer emits one byte per
// cycle while the sink is ready. An item's text is 1 byte when it passes
// through, 4 to 6 bytes for a named entity and 3 + digits (6 to 10) bytes for
// a numeric one. Input beats are taken every cycle while the four-entry queue
// between the classifier and the sequencer has room. From an empty block the
// first byte passes the classifier register, the queue and the sequencer.
module html_entity_escaper_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [hee_pkg::IN_DATA_W-1:0]  i_s_tdata,   // [20:0] code_point, [23:21] zero
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata,   // [7:0] out_byte
    output logic                           o_m_tlast
);

    logic           push;
    logic           push_ready;
    hee_pkg::t_item push_item;
    logic           pop_valid;
    logic           pop;
    hee_pkg::t_item pop_item;

    hee_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_cp         (i_s_tdata[hee_pkg::CP_W-1:0]),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_item       (push_item)
    );

    hee_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_item       (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_item       (pop_item),
        .i_pop        (pop)
    );

    hee_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_item      (pop_item),
        .o_pop       (pop),
        .o_tvalid    (o_m_tvalid),
        .i_tready    (i_m_tready),
        .o_tdata     (o_m_tdata),
        .o_tlast     (o_m_tlast)
    );

endmodule

// ===== tb/tb_html_entity_escaper_unit.sv =====
`timescale 1ns / 1ps

module tb_html_entity_escaper_unit;

    localparam int RANDOM_ITEMS = 450;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        hee_pkg::t_byte data;
        logic           last;
    } t_esc_byte;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [hee_pkg::IN_DATA_W-1:0] i_s_tdata  = '0;   // [20:0] code_point, [23:21] zero
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [7:0]                    o_m_tdata;         // [7:0] out_byte
    logic                          o_m_tlast;

    hee_pkg::t_cp cp_pend_q[$];
    t_esc_byte    esc_exp_q[$];
    int           total_cps;
    int           sent_cnt;
    int           err_cnt;
    int           stall_cycles;

    html_entity_escaper_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Traffic phase: 0 = sender light / receiver heavy idling, 1 = swapped, 2 = none.
    function automatic int traffic_phase();
        if (sent_cnt * 3 < total_cps) return 0;
        if (sent_cnt * 3 < total_cps * 2) return 1;
        return 2;
    endfunction

    // Append the escaped text of one code point to the expected byte stream.
    function automatic void predict_escape(hee_pkg::t_cp cp);
        string     txt;
        int        i;
        t_esc_byte b;
        case (cp)
            hee_pkg::CP_AMP:  txt = "&amp;";
            hee_pkg::CP_QUOT: txt = "&quot;";
            hee_pkg::CP_APOS: txt = "&#039;";
            hee_pkg::CP_LT:   txt = "&lt;";
            hee_pkg::CP_GT:   txt = "&gt;";
            default: begin
                if (cp < hee_pkg::CP_ASCII_LIMIT) begin
                    b.data = cp[7:0];
                    b.last = 1'b1;
                    esc_exp_q.push_back(b);
                    return;
                end
                txt = $sformatf("&#%0d;", cp);
            end
        endcase
        for (i = 0; i < txt.len(); i++) begin
            b.data = txt[i];
            b.last = (i == txt.len() - 1);
            esc_exp_q.push_back(b);
        end
    endfunction

    function automatic hee_pkg::t_cp random_code_point();
        int           sel;
        int           ndig;
        int           lo;
        int           hi;
        hee_pkg::t_cp markup[5];
        markup = '{hee_pkg::CP_AMP, hee_pkg::CP_QUOT, hee_pkg::CP_APOS,
                   hee_pkg::CP_LT, hee_pkg::CP_GT};
        sel = $urandom_range(99);
        if (sel < 45) return hee_pkg::t_cp'($urandom_range(127));
        if (sel < 60) return markup[$urandom_range(4)];
        if (sel < 80) begin
            // pick a digit count, then a value inside that decade
            ndig = $urandom_range(7, 3);
            lo = (ndig == 3) ? 128 : 10 ** (ndig - 1);
            hi = (ndig == 7) ? 2097151 : 10 ** ndig - 1;
            return hee_pkg::t_cp'($urandom_range(hi, lo));
        end
        return hee_pkg::t_cp'($urandom());
    endfunction

    // Source side: present the next code point unless idling this cycle.
    always @(posedge i_clk) begin
        int idle_pct;
        idle_pct = (traffic_phase() == 0) ? 16 : (traffic_phase() == 1) ? 81 : 0;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (cp_pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {3'b000, cp_pend_q.pop_front()};
                sent_cnt   <= sent_cnt + 1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Sink side backpressure.
    always @(posedge i_clk) begin
        int idle_pct;
        idle_pct = (traffic_phase() == 0) ? 81 : (traffic_phase() == 1) ? 16 : 0;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Predict on each input beat, then check each output beat against the oldest byte.
    always @(posedge i_clk) begin
        t_esc_byte want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                predict_escape(i_s_tdata[hee_pkg::CP_W-1:0]);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (esc_exp_q.size() == 0) begin
                    $display("%0t: unexpected beat: expected none actual tdata=%02h tlast=%0b",
                             $time, o_m_tdata, o_m_tlast);
                    err_cnt++;
                end else begin
                    want = esc_exp_q.pop_front();
                    if (o_m_tdata !== want.data) begin
                        $display("%0t: out_byte mismatch: expected %02h actual %02h",
                                 $time, want.data, o_m_tdata);
                        err_cnt++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $display("%0t: run_end mismatch: expected %0b actual %0b",
                                 $time, want.last, o_m_tlast);
                        err_cnt++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        hee_pkg::t_cp directed[$];
        int           i;
        sent_cnt     = 0;
        err_cnt      = 0;
        stall_cycles = 0;

        // zero, markup characters and their neighbors, ASCII edge, every digit count
        directed = '{21'd0, hee_pkg::CP_AMP, hee_pkg::CP_QUOT, hee_pkg::CP_APOS,
                     hee_pkg::CP_LT, hee_pkg::CP_GT, 21'h23, 21'h3b,
                     21'h41, 21'd127, 21'd128, 21'd999, 21'd1000, 21'd9999,
                     21'd10000, 21'd99999, 21'd100000, 21'd999999, 21'd1000000,
                     21'h00d800, 21'h10ffff, 21'h110000, 21'h1fffff};
        foreach (directed[i]) cp_pend_q.push_back(directed[i]);
        for (i = 0; i < RANDOM_ITEMS; i++) cp_pend_q.push_back(random_code_point());
        total_cps = cp_pend_q.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cp_pend_q.size() > 0 || i_s_tvalid) @(posedge i_clk);
        while (esc_exp_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0 && esc_exp_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hee_pkg.sv
rtl/hee_front.sv
rtl/hee_fifo.sv
rtl/hee_back.sv
rtl/html_entity_escaper_unit.sv
tb/tb_html_entity_escaper_unit.sv
